FILE: rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: assertion failed");

// post must hold in the cycle after pre
`define ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("%m: assertion failed");

`endif

FILE: rtl/pfle_pkg.sv
package pfle_pkg;

   // message geometry
   localparam int unsigned MAX_MSG_BYTES = 65536;
   localparam int          LEFT_W        = 17;
   localparam int          COUNT_W       = 5;
   localparam logic [COUNT_W-1:0] VALUE_LIMIT = 5'd16;
   localparam logic [COUNT_W-1:0] MAX_VALUES_RST = 5'd4;

   // varint accumulator keeps the low bits exactly, the rest as a sticky flag
   localparam int          ACC_W            = 17;
   localparam logic [3:0]  VARINT_LAST_SHIFT = 4'd9;

   // field we collect
   localparam logic [ACC_W-4:0] FLOAT_FIELD = 14'd1;

   // wire types
   localparam logic [2:0] WT_VARINT = 3'd0;
   localparam logic [2:0] WT_I64    = 3'd1;
   localparam logic [2:0] WT_LEN    = 3'd2;
   localparam logic [2:0] WT_I32    = 3'd5;

   // fixed entry sizes
   localparam logic [LEFT_W-1:0] I64_BYTES = 17'd8;
   localparam logic [LEFT_W-1:0] I32_BYTES = 17'd4;

   // stop causes
   localparam logic [2:0] STOP_CLEAN      = 3'd0;
   localparam logic [2:0] STOP_MAX        = 3'd1;
   localparam logic [2:0] STOP_BAD_VARINT = 3'd2;
   localparam logic [2:0] STOP_BAD_WIRE   = 3'd3;
   localparam logic [2:0] STOP_OVERRUN    = 3'd4;

   typedef enum logic [1:0] {
      PH_KEY   = 2'd0,
      PH_VSKIP = 2'd1,
      PH_LEN   = 2'd2,
      PH_SPAN  = 2'd3
   } phase_type;

   typedef struct packed {
      logic             done;
      logic             overflow;
      logic [ACC_W-1:0] value_lo;
      logic             value_hi;
      logic [ACC_W-1:0] acc_lo_next;
      logic             hi_next;
      logic [3:0]       shift_next;
   } varint_res_type;

   typedef struct packed {
      logic               produce;
      logic               has_value;
      logic [31:0]        value_bits;
      logic [3:0]         value_index;
      logic               is_final;
      logic [COUNT_W-1:0] value_count;
      logic [2:0]         stop_cause;
   } result_type;

endpackage

FILE: rtl/pfle_varint.sv
module pfle_varint (
   input  logic [7:0]                 data_byte,
   input  logic [3:0]                 shift,
   input  logic [pfle_pkg::ACC_W-1:0] acc_lo,
   input  logic                       acc_hi,
   output pfle_pkg::varint_res_type   res
);

   logic [6:0]                 group;
   logic [pfle_pkg::ACC_W-1:0] lo_new;
   logic                       hi_add;

   assign group = data_byte[6:0];

   // place the 7-bit group; bits above the kept window only set the flag
   always_comb begin
      lo_new = acc_lo;
      hi_add = 1'b0;
      case (shift) inside
         4'd0: lo_new[6:0] = acc_lo[6:0] | group;
         4'd1: lo_new[13:7] = acc_lo[13:7] | group;
         4'd2: begin
            lo_new[16:14] = acc_lo[16:14] | group[2:0];
            hi_add = |group[6:3];
         end
         [4'd3:4'd8]: hi_add = |group;
         4'd9: hi_add = group[0];
         default: hi_add = 1'b0;
      endcase
   end

   // completion, overflow and next accumulator
   always_comb begin
      res.value_lo = lo_new;
      res.value_hi = acc_hi | hi_add;
      res.done     = ~data_byte[7];
      res.overflow = data_byte[7] && (shift >= pfle_pkg::VARINT_LAST_SHIFT);
      if (res.done) begin
         res.acc_lo_next = '0;
         res.hi_next     = 1'b0;
         res.shift_next  = 4'd0;
      end else begin
         res.acc_lo_next = lo_new;
         res.hi_next     = acc_hi | hi_add;
         res.shift_next  = 4'(shift + 4'd1);
      end
   end

endmodule

FILE: rtl/pfle_parser.sv
module pfle_parser (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  logic [7:0]                           data_byte,
   input  logic [pfle_pkg::LEFT_W-1:0]          bytes_left,
   input  logic [pfle_pkg::COUNT_W-1:0]         max_values,
   output pfle_pkg::result_type                 result
);

   pfle_pkg::phase_type                phase_ff, phase_in;
   logic [pfle_pkg::ACC_W-1:0]         acc_lo_ff, acc_lo_in;
   logic                               acc_hi_ff, acc_hi_in;
   logic [3:0]                         shift_ff, shift_in;
   logic                               fone_ff, fone_in;
   logic [pfle_pkg::LEFT_W-1:0]        span_ff, span_in;
   logic [23:0]                        word_ff, word_in;
   logic [1:0]                         pos_ff, pos_in;
   logic [pfle_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic                               halted_ff, halted_in;
   logic [2:0]                         cause_ff, cause_in;

   pfle_pkg::varint_res_type           vr;
   logic                               last;
   logic [pfle_pkg::LEFT_W-1:0]        rem;
   logic [pfle_pkg::COUNT_W-1:0]       lim;
   logic                               has;
   logic [31:0]                        val;
   logic [3:0]                         idx;
   logic [2:0]                         wt;
   logic                               f1;
   logic [2:0]                         end_cause;

   localparam logic [pfle_pkg::LEFT_W-1:0] MAX_LEFT = pfle_pkg::LEFT_W'(pfle_pkg::MAX_MSG_BYTES);

   pfle_varint u_varint (
      .data_byte (data_byte),
      .shift     (shift_ff),
      .acc_lo    (acc_lo_ff),
      .acc_hi    (acc_hi_ff),
      .res       (vr)
   );

   // byte position, value limit, wire type and field match
   always_comb begin
      last = (bytes_left <= pfle_pkg::LEFT_W'(1));
      if (bytes_left == '0) begin
         rem = '0;
      end else if (bytes_left > MAX_LEFT) begin
         rem = MAX_LEFT - pfle_pkg::LEFT_W'(1);
      end else begin
         rem = bytes_left - pfle_pkg::LEFT_W'(1);
      end
      lim = (max_values > pfle_pkg::VALUE_LIMIT) ? pfle_pkg::VALUE_LIMIT : max_values;
      wt  = vr.value_lo[2:0];
      f1  = ~vr.value_hi && (vr.value_lo[pfle_pkg::ACC_W-1:3] == pfle_pkg::FLOAT_FIELD);
   end

   // next state
   always_comb begin
      phase_in  = phase_ff;
      acc_lo_in = acc_lo_ff;
      acc_hi_in = acc_hi_ff;
      shift_in  = shift_ff;
      fone_in   = fone_ff;
      span_in   = span_ff;
      word_in   = word_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      halted_in = halted_ff;
      cause_in  = cause_ff;
      has       = 1'b0;
      val       = '0;
      idx       = '0;

      // limit already met (or zero) stops before the byte is looked at
      if (!halted_ff && (count_ff >= lim)) begin
         halted_in = 1'b1;
         cause_in  = pfle_pkg::STOP_MAX;
      end

      if (!halted_in) begin
         if (phase_ff == pfle_pkg::PH_SPAN) begin
            span_in = span_ff - pfle_pkg::LEFT_W'(1);
            if (fone_ff) begin
               case (pos_ff)
                  2'd0: word_in[7:0]   = data_byte;
                  2'd1: word_in[15:8]  = data_byte;
                  2'd2: word_in[23:16] = data_byte;
                  default: begin
                     has      = 1'b1;
                     val      = {data_byte, word_ff};
                     idx      = count_ff[3:0];
                     count_in = pfle_pkg::COUNT_W'(count_ff + pfle_pkg::COUNT_W'(1));
                     word_in  = '0;
                     if (count_in >= lim) begin
                        halted_in = 1'b1;
                        cause_in  = pfle_pkg::STOP_MAX;
                     end
                  end
               endcase
               pos_in = 2'(pos_ff + 2'd1);
            end
            if (span_in == '0) begin
               phase_in = pfle_pkg::PH_KEY;
               fone_in  = 1'b0;
               pos_in   = '0;
               word_in  = '0;
            end
         end else begin
            acc_lo_in = vr.acc_lo_next;
            acc_hi_in = vr.hi_next;
            shift_in  = vr.shift_next;
            if (vr.overflow) begin
               halted_in = 1'b1;
               cause_in  = pfle_pkg::STOP_BAD_VARINT;
            end else if (vr.done) begin
               unique case (phase_ff)
                  pfle_pkg::PH_KEY: begin
                     if (wt == pfle_pkg::WT_VARINT) begin
                        phase_in = pfle_pkg::PH_VSKIP;
                     end else if (wt == pfle_pkg::WT_LEN) begin
                        fone_in  = f1;
                        phase_in = pfle_pkg::PH_LEN;
                     end else if (wt == pfle_pkg::WT_I64 || wt == pfle_pkg::WT_I32) begin
                        if (rem < ((wt == pfle_pkg::WT_I64) ? pfle_pkg::I64_BYTES
                                                              : pfle_pkg::I32_BYTES)) begin
                           halted_in = 1'b1;
                           cause_in  = pfle_pkg::STOP_OVERRUN;
                        end else begin
                           fone_in  = f1 && (wt == pfle_pkg::WT_I32);
                           pos_in   = '0;
                           word_in  = '0;
                           span_in  = (wt == pfle_pkg::WT_I64) ? pfle_pkg::I64_BYTES
                                                                : pfle_pkg::I32_BYTES;
                           phase_in = pfle_pkg::PH_SPAN;
                        end
                     end else begin
                        halted_in = 1'b1;
                        cause_in  = pfle_pkg::STOP_BAD_WIRE;
                     end
                  end
                  pfle_pkg::PH_VSKIP: phase_in = pfle_pkg::PH_KEY;
                  pfle_pkg::PH_LEN: begin
                     if (vr.value_hi || (vr.value_lo > rem)) begin
                        halted_in = 1'b1;
                        cause_in  = pfle_pkg::STOP_OVERRUN;
                     end else begin
                        pos_in  = '0;
                        word_in = '0;
                        if (vr.value_lo == '0) begin
                           phase_in = pfle_pkg::PH_KEY;
                           fone_in  = 1'b0;
                        end else begin
                           span_in  = vr.value_lo;
                           phase_in = pfle_pkg::PH_SPAN;
                        end
                     end
                  end
                  default: phase_in = phase_ff;
               endcase
            end
         end
      end
   end

   // stop cause seen on the last byte
   always_comb begin
      if (!last || halted_in) begin
         end_cause = cause_in;
      end else if (shift_in != 4'd0) begin
         end_cause = pfle_pkg::STOP_BAD_VARINT;
      end else if (phase_in == pfle_pkg::PH_KEY) begin
         end_cause = pfle_pkg::STOP_CLEAN;
      end else if (phase_in == pfle_pkg::PH_SPAN) begin
         end_cause = pfle_pkg::STOP_OVERRUN;
      end else begin
         end_cause = pfle_pkg::STOP_BAD_VARINT;
      end
   end

   // result word
   always_comb begin
      result.produce     = has || last;
      result.has_value   = has;
      result.value_bits  = val;
      result.value_index = idx;
      result.is_final    = last;
      result.value_count = last ? count_in : '0;
      result.stop_cause  = last ? end_cause : pfle_pkg::STOP_CLEAN;
   end

   // parser state; the last byte returns everything to the idle values
   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         phase_ff  <= pfle_pkg::PH_KEY;
         acc_lo_ff <= '0;
         acc_hi_ff <= 1'b0;
         shift_ff  <= '0;
         fone_ff   <= 1'b0;
         span_ff   <= '0;
         word_ff   <= '0;
         pos_ff    <= '0;
         count_ff  <= '0;
         halted_ff <= 1'b0;
         cause_ff  <= pfle_pkg::STOP_CLEAN;
      end else if (step) begin
         phase_ff  <= phase_in;
         acc_lo_ff <= acc_lo_in;
         acc_hi_ff <= acc_hi_in;
         shift_ff  <= shift_in;
         fone_ff   <= fone_in;
         span_ff   <= span_in;
         word_ff   <= word_in;
         pos_ff    <= pos_in;
         count_ff  <= count_in;
         halted_ff <= halted_in;
         cause_ff  <= cause_in;
      end
   end

endmodule

FILE: rtl/protobuf_float_list_extract.sv
// Protobuf float-list extractor. Feed one message byte per req word together
// with the count of bytes left in the message (this byte included; 1 or 0
// marks the last byte). Field 1 entries sent as fixed32 or as a packed run
// come out as raw 32-bit float words, one rsp word per completed value, and
// the last byte always yields an rsp word carrying is_final, the value count
// and the stop cause. Each byte is held in the input register, parsed
// against the parser registers in a single pass and placed in the output
// register, so a new byte is taken every cycle while rsp is not stalled.
// rsp_valid rises when the accepted byte moves from the input register into
// the output register. csr_max_values sets the value limit (reset 4, above
// 16 acts as 16) and is to be written only between messages by the user;
// the block itself does not enforce this.
module protobuf_float_list_extract (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_data_byte,
   input  logic [pfle_pkg::LEFT_W-1:0]          req_bytes_left,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_has_value,
   output logic [31:0]                          rsp_value_bits,
   output logic [3:0]                           rsp_value_index,
   output logic                                 rsp_is_final,
   output logic [pfle_pkg::COUNT_W-1:0]         rsp_value_count,
   output logic [2:0]                           rsp_stop_cause,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pfle_pkg::COUNT_W-1:0]         csr_max_values
);

   logic                               in_valid_ff, in_valid_in;
   logic [7:0]                         in_byte_ff;
   logic [pfle_pkg::LEFT_W-1:0]        in_left_ff;
   logic                               out_valid_ff, out_valid_in;
   pfle_pkg::result_type               out_ff;
   logic [pfle_pkg::COUNT_W-1:0]       max_ff;
   pfle_pkg::result_type               result;
   logic                               accept;
   logic                               advance;

   // config register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= pfle_pkg::MAX_VALUES_RST;
      end else if (csr_valid && csr_ready) begin
         max_ff <= csr_max_values;
      end
   end

   // flow control: the held byte moves on when the output slot frees up
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = result.produce;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept) begin
         in_byte_ff <= req_data_byte;
         in_left_ff <= req_bytes_left;
      end
   end

   pfle_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .data_byte  (in_byte_ff),
      .bytes_left (in_left_ff),
      .max_values (max_ff),
      .result     (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_has_value   = out_ff.has_value;
   assign rsp_value_bits  = out_ff.value_bits;
   assign rsp_value_index = out_ff.value_index;
   assign rsp_is_final    = out_ff.is_final;
   assign rsp_value_count = out_ff.value_count;
   assign rsp_stop_cause  = out_ff.stop_cause;

endmodule

FILE: rtl/pfle_checker.sv
`include "assert_macros.svh"

module pfle_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic                                 rsp_has_value,
   input logic [31:0]                          rsp_value_bits,
   input logic [3:0]                           rsp_value_index,
   input logic                                 rsp_is_final,
   input logic [pfle_pkg::COUNT_W-1:0]         rsp_value_count,
   input logic [2:0]                           rsp_stop_cause
);

   logic summary_clear;
   logic value_clear;
   logic in_range;

   assign summary_clear = (rsp_value_count == '0) && (rsp_stop_cause == pfle_pkg::STOP_CLEAN);
   assign value_clear   = (rsp_value_bits == '0) && (rsp_value_index == '0);
   assign in_range      = (rsp_stop_cause <= pfle_pkg::STOP_OVERRUN)
                          && (rsp_value_count <= pfle_pkg::VALUE_LIMIT);

   // a stalled rsp word stays up
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // a word without a value only comes on the last byte
   `ASSERT_ALWAYS(a_rsp_reason, clock, reset, !rsp_valid || rsp_has_value || rsp_is_final)

   // summary fields are clear except on the final word
   `ASSERT_ALWAYS(a_rsp_summary, clock, reset, !rsp_valid || rsp_is_final || summary_clear)

   // value fields are clear when no value completed
   `ASSERT_ALWAYS(a_rsp_novalue, clock, reset, !rsp_valid || rsp_has_value || value_clear)

   // stop cause and count stay in their legal range
   `ASSERT_ALWAYS(a_rsp_range, clock, reset, !rsp_valid || in_range)

endmodule

bind protobuf_float_list_extract pfle_checker u_pfle_checker (.*);

FILE: tb/protobuf_float_list_extract_tb.sv
`timescale 1ns / 1ps

module protobuf_float_list_extract_tb;

   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 6;
   localparam int PHASE_BYTES = 44;
   // wire types the block rejects
   localparam logic [2:0] BAD_WIRE [4] = '{3'd3, 3'd4, 3'd6, 3'd7};

   typedef struct {
      bit [7:0]                  data;
      bit [pfle_pkg::LEFT_W-1:0] left;
   } byte_item_type;

   typedef struct {
      bit                         has;
      bit [31:0]                  bits;
      bit [3:0]                   idx;
      bit                         last;
      bit [pfle_pkg::COUNT_W-1:0] count;
      bit [2:0]                   cause;
   } float_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [7:0]                    req_data_byte = '0;
   logic [pfle_pkg::LEFT_W-1:0]   req_bytes_left = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_has_value;
   logic [31:0]                   rsp_value_bits;
   logic [3:0]                    rsp_value_index;
   logic                          rsp_is_final;
   logic [pfle_pkg::COUNT_W-1:0]  rsp_value_count;
   logic [2:0]                    rsp_stop_cause;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [pfle_pkg::COUNT_W-1:0]  csr_max_values = '0;

   protobuf_float_list_extract dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_bytes_left  (req_bytes_left),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_has_value   (rsp_has_value),
      .rsp_value_bits  (rsp_value_bits),
      .rsp_value_index (rsp_value_index),
      .rsp_is_final    (rsp_is_final),
      .rsp_value_count (rsp_value_count),
      .rsp_stop_cause  (rsp_stop_cause),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_max_values  (csr_max_values)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 0;
   end

   // stimulus and scoreboard state
   byte_item_type  bytes_to_send [$];
   float_word_type float_words_due [$];
   bit [7:0]       msg_q [$];
   bit             req_busy = 0;
   bit             calm = 0;
   int             gap_left = 0;
   int             stall_left = 0;
   int             hold_left = 0;
   int             hold_req_len = 0;
   int             mismatches = 0;
   int             cycles = 0;
   int             bytes_taken = 0;
   int             msg_count = 0;
   int             words_seen = 0;
   int             cause_seen [5] = '{0, 0, 0, 0, 0};

   // parser shadow state
   bit [pfle_pkg::COUNT_W-1:0] max_vals;
   pfle_pkg::phase_type        parse_phase;
   bit [63:0]                  vacc;
   int                         vshift;
   bit                         collect;
   int                         span_left;
   bit [31:0]                  word_acc;
   int                         word_pos;
   int                         count_out;
   bit                         halted;
   bit [2:0]                   halt_cause;

   task automatic clear_message();
      parse_phase = pfle_pkg::PH_KEY;
      vacc = '0;
      vshift = 0;
      collect = 0;
      span_left = 0;
      word_acc = '0;
      word_pos = 0;
      count_out = 0;
      halted = 0;
      halt_cause = pfle_pkg::STOP_CLEAN;
   endtask

   task automatic halt_parse(input bit [2:0] cause);
      halted = 1;
      halt_cause = cause;
   endtask

   task automatic open_span(input int len, input bit keep);
      collect = keep;
      word_pos = 0;
      word_acc = '0;
      if (len == 0) begin
         parse_phase = pfle_pkg::PH_KEY;
         collect = 0;
      end else begin
         span_left = len;
         parse_phase = pfle_pkg::PH_SPAN;
      end
   endtask

   // advance the shadow parser by one byte, queue the word it yields
   task automatic parse_byte(input bit [7:0] b, input bit [pfle_pkg::LEFT_W-1:0] left);
      bit             last;
      int unsigned    eff;
      int unsigned    rem;
      int unsigned    lim;
      int unsigned    need;
      bit [63:0]      v;
      bit             done;
      bit [2:0]       wt;
      bit             f1;
      float_word_type w;
      last = (left <= 1);
      eff = (left == 0) ? 1 : left;
      if (eff > pfle_pkg::MAX_MSG_BYTES) eff = pfle_pkg::MAX_MSG_BYTES;
      rem = eff - 1;
      lim = (max_vals > pfle_pkg::VALUE_LIMIT) ? pfle_pkg::VALUE_LIMIT : max_vals;
      done = 0;
      v = '0;
      w = '{default: 0};
      if (!halted && count_out >= lim) halt_parse(pfle_pkg::STOP_MAX);
      if (!halted) begin
         if (parse_phase == pfle_pkg::PH_SPAN) begin
            span_left--;
            if (collect) begin
               if (word_pos < 3) begin
                  word_acc |= 32'(b) << (8 * word_pos);
                  word_pos++;
               end else begin
                  w.has = 1;
                  w.bits = word_acc | (32'(b) << 24);
                  w.idx = 4'(count_out);
                  count_out++;
                  word_pos = 0;
                  word_acc = '0;
                  if (count_out >= lim) halt_parse(pfle_pkg::STOP_MAX);
               end
            end
            if (span_left == 0) begin
               parse_phase = pfle_pkg::PH_KEY;
               collect = 0;
               word_pos = 0;
               word_acc = '0;
            end
         end else begin
            // varint byte: key, skipped value or length
            vacc |= 64'(b & 8'h7f) << (7 * (vshift % 10));
            if (!b[7]) begin
               v = vacc;
               vacc = '0;
               vshift = 0;
               done = 1;
            end else begin
               vshift++;
               if (vshift >= 10) halt_parse(pfle_pkg::STOP_BAD_VARINT);
            end
            if (done) begin
               if (parse_phase == pfle_pkg::PH_KEY) begin
                  wt = v[2:0];
                  f1 = ((v >> 3) == 64'(pfle_pkg::FLOAT_FIELD));
                  if (wt == pfle_pkg::WT_VARINT) begin
                     parse_phase = pfle_pkg::PH_VSKIP;
                  end else if (wt == pfle_pkg::WT_LEN) begin
                     collect = f1;
                     parse_phase = pfle_pkg::PH_LEN;
                  end else if (wt == pfle_pkg::WT_I64 || wt == pfle_pkg::WT_I32) begin
                     need = (wt == pfle_pkg::WT_I64) ? pfle_pkg::I64_BYTES
                                                     : pfle_pkg::I32_BYTES;
                     if (rem < need) halt_parse(pfle_pkg::STOP_OVERRUN);
                     else open_span(need, f1 && wt == pfle_pkg::WT_I32);
                  end else begin
                     halt_parse(pfle_pkg::STOP_BAD_WIRE);
                  end
               end else if (parse_phase == pfle_pkg::PH_VSKIP) begin
                  parse_phase = pfle_pkg::PH_KEY;
               end else begin
                  if (v > 64'(rem)) halt_parse(pfle_pkg::STOP_OVERRUN);
                  else open_span(int'(v), collect);
               end
            end
         end
      end
      // cause for a message that ends mid-element
      if (last && !halted) begin
         if (vshift != 0) halt_cause = pfle_pkg::STOP_BAD_VARINT;
         else if (parse_phase == pfle_pkg::PH_KEY) halt_cause = pfle_pkg::STOP_CLEAN;
         else if (parse_phase == pfle_pkg::PH_SPAN) halt_cause = pfle_pkg::STOP_OVERRUN;
         else halt_cause = pfle_pkg::STOP_BAD_VARINT;
      end
      if (w.has || last) begin
         w.last = last;
         w.count = last ? pfle_pkg::COUNT_W'(count_out) : '0;
         w.cause = last ? halt_cause : pfle_pkg::STOP_CLEAN;
         float_words_due.push_back(w);
      end
      if (last) clear_message();
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // monitor: results, register writes and accepted bytes
   always @(posedge clock) begin : watch
      float_word_type want;
      if (reset) begin
         max_vals = pfle_pkg::MAX_VALUES_RST;
         clear_message();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (float_words_due.size() == 0) begin
               $error("result word with nothing expected: value_bits %0h is_final %0b",
                      rsp_value_bits, rsp_is_final);
               mismatches++;
            end else begin
               want = float_words_due.pop_front();
               check_field("has_value", want.has, rsp_has_value);
               check_field("value_bits", want.bits, rsp_value_bits);
               check_field("value_index", want.idx, rsp_value_index);
               check_field("is_final", want.last, rsp_is_final);
               check_field("value_count", want.count, rsp_value_count);
               check_field("stop_cause", want.cause, rsp_stop_cause);
               if (want.has) words_seen++;
               if (want.last) cause_seen[want.cause]++;
            end
         end
         if (csr_valid && csr_ready) max_vals = csr_max_values;
         if (req_valid && !req_stall) begin
            parse_byte(req_data_byte, req_bytes_left);
            req_busy = 0;
            bytes_taken++;
         end
      end
   end

   // byte sender with random gaps
   always @(negedge clock) begin : drive_bytes
      int r;
      byte_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_busy) begin
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (bytes_to_send.size() != 0) begin
            it = bytes_to_send.pop_front();
            req_data_byte <= it.data;
            req_bytes_left <= it.left;
            req_valid <= 1'b1;
            req_busy = 1;
            r = $urandom_range(0, 99);
            if (calm || r < 60) gap_left = 0;
            else if (r < 92) gap_left = $urandom_range(1, 3);
            else gap_left = $urandom_range(8, 30);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver: random stalls, plus one long hold-off on request
   always @(negedge clock) begin : pace_rsp
      int r;
      if (reset || calm) begin
         rsp_stall <= 1'b0;
      end else if (hold_req_len != 0) begin
         hold_left = hold_req_len;
         hold_req_len = 0;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            rsp_stall <= 1'b0;
         end else begin
            stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
            rsp_stall <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("protobuf_float_list_extract test failed");
         $finish;
      end
   end

   task automatic add_varint(input bit [63:0] v);
      bit [7:0] b;
      do begin
         b = {1'b0, v[6:0]};
         v = v >> 7;
         if (v != 0) b[7] = 1'b1;
         msg_q.push_back(b);
      end while (v != 0);
   endtask

   task automatic add_key(input int fn, input bit [2:0] wt);
      add_varint((64'(fn) << 3) | 64'(wt));
   endtask

   task automatic add_noise(input int n);
      repeat (n) msg_q.push_back(8'($urandom_range(0, 255)));
   endtask

   // hand the built message to the sender; odd_left uses the extreme counts
   task automatic send_message(input bit odd_left);
      byte_item_type it;
      int n;
      n = msg_q.size();
      for (int i = 0; i < n; i++) begin
         it.data = msg_q[i];
         it.left = pfle_pkg::LEFT_W'(n - i);
         if (odd_left && i == 0) it.left = '1;
         if (odd_left && i == n - 1) it.left = '0;
         bytes_to_send.push_back(it);
      end
      msg_q.delete();
      msg_count++;
   endtask

   task automatic build_random_message();
      int nfields;
      int kind;
      int len;
      int cut;
      nfields = $urandom_range(1, 6);
      repeat (nfields) begin
         kind = $urandom_range(0, 99);
         if (kind < 25) begin
            add_key(1, pfle_pkg::WT_I32);
            add_noise(4);
         end else if (kind < 45) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 40)
                                              : $urandom_range(0, 13);
            add_key(1, pfle_pkg::WT_LEN);
            add_varint(len);
            add_noise(len);
         end else if (kind < 55) begin
            add_key($urandom_range(2, 3000), pfle_pkg::WT_VARINT);
            add_varint({$urandom, $urandom} >> $urandom_range(0, 63));
         end else if (kind < 63) begin
            len = $urandom_range(0, 6);
            add_key($urandom_range(2, 3000), pfle_pkg::WT_LEN);
            add_varint(len);
            add_noise(len);
         end else if (kind < 66) begin
            add_key($urandom_range(1, 3), pfle_pkg::WT_I64);
            add_noise(8);
         end else if (kind < 68) begin
            add_key($urandom_range(2, 3000), pfle_pkg::WT_I32);
            add_noise(4);
         end else if (kind < 71) begin
            add_key(1, pfle_pkg::WT_VARINT);
            add_varint($urandom_range(0, 100000));
         end else if (kind < 74) begin
            add_key($urandom_range(1, 3000), BAD_WIRE[$urandom_range(0, 3)]);
         end else if (kind < 77) begin
            // varint that never ends within ten bytes
            repeat (10) msg_q.push_back(8'h80 | 8'($urandom_range(0, 127)));
            add_noise(1);
         end else if (kind < 80) begin
            // field 1 fixed32 key with far high bits set: not field 1
            add_varint((64'(pfle_pkg::FLOAT_FIELD) << 3) | 64'(pfle_pkg::WT_I32)
                       | (64'($urandom_range(1, 255)) << $urandom_range(17, 56)));
            add_noise(4);
         end else if (kind < 83) begin
            add_key($urandom_range(1, 3), pfle_pkg::WT_LEN);
            add_varint($urandom_range(50, 70000));
         end else if (kind < 86) begin
            // padded key encoding of field 1 fixed32
            msg_q.push_back(8'h8d);
            msg_q.push_back(8'h80);
            msg_q.push_back(8'h00);
            add_noise(4);
         end else begin
            add_noise($urandom_range(1, 3));
         end
      end
      // some messages end mid-element
      if (msg_q.size() > 1 && $urandom_range(0, 99) < 15) begin
         cut = $urandom_range(1, msg_q.size() - 1);
         while (msg_q.size() > cut) void'(msg_q.pop_back());
      end
   endtask

   task automatic write_max(input bit [pfle_pkg::COUNT_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_max_values <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // sender pauses here until every queued byte is in and every word is out
   task automatic drain();
      while (bytes_to_send.size() != 0 || req_busy || float_words_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      bit [pfle_pkg::COUNT_W-1:0] max_plan [8];
      int n;
      max_plan = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd4, 5'd16, 5'd2};
      max_plan[5] = $urandom_range(1, 16);
      max_plan[7] = $urandom_range(1, 16);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed messages at the reset value of max_values
      msg_q = '{8'h0d, 8'h00, 8'hff, 8'h80, 8'h7f};          // one fixed32 word
      send_message(0);
      msg_q = '{8'h0a, 8'h05, 8'hff, 8'hff, 8'hff, 8'hff, 8'h12};  // packed, short tail
      send_message(1);
      msg_q = '{8'h08};                                      // ends after key
      send_message(1);
      msg_q = '{8'h0b, 8'h55};                               // bad wire type
      send_message(0);
      msg_q = '{8'h12, 8'h7f, 8'h00};                        // length past the end
      send_message(0);
      msg_q = '{8'h0d, 8'h01, 8'h02};                        // fixed32 cut short
      send_message(0);
      drain();

      // random phases, one max_values setting each
      for (int p = 0; p < 8; p++) begin
         write_max(max_plan[p]);
         calm = (p == 4);
         if (p == 1) hold_req_len = 300;
         n = 0;
         while (n < PHASE_BYTES) begin
            build_random_message();
            n += msg_q.size();
            send_message($urandom_range(0, 9) == 0);
         end
         drain();
         calm = 0;
      end

      $display("covered %0d bytes in %0d messages with %0d float words", bytes_taken,
               msg_count, words_seen);
      $display("stop causes clean/max/varint/wire/overrun: %0d/%0d/%0d/%0d/%0d",
               cause_seen[0], cause_seen[1], cause_seen[2], cause_seen[3], cause_seen[4]);
      if (mismatches == 0) begin
         $display("protobuf_float_list_extract test passed");
      end else begin
         $display("protobuf_float_list_extract test failed");
      end
      $finish;
   end

endmodule
